// ----- rtl/core/cp_tensor_entry_eval_defines.svh -----
// Assertion macros for the CP tensor entry evaluator
`ifndef CP_TENSOR_ENTRY_EVAL_DEFINES_SVH
`define CP_TENSOR_ENTRY_EVAL_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CPTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cpte_pkg.sv -----
// Types, codes and constants shared by the CP tensor entry evaluator
`default_nettype none

package cpte_pkg;

  localparam int unsigned MAX_DIMS_DEF   = 4;
  localparam int unsigned MAX_EXTENT_DEF = 64;
  localparam int unsigned MAX_RANK_DEF   = 16;
  localparam int unsigned FRAC_BITS_DEF  = 14;

  localparam int unsigned VAL_W      = 16;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned NUM_POS    = 4;
  localparam int unsigned ENTRY_W    = 40;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned DIMS_REG_W = 3;
  localparam int unsigned RANK_REG_W = 5;
  localparam int unsigned EXT_REG_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT3 = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_POS_ERR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_WR_ERR  = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

  typedef struct packed {
    logic                    mode;
    logic [1:0]              write_dim;
    logic [5:0]              write_row;
    logic [3:0]              write_term;
    logic signed [VAL_W-1:0] write_value;
    logic [POS_W-1:0]        pos0;
    logic [POS_W-1:0]        pos1;
    logic [POS_W-1:0]        pos2;
    logic [POS_W-1:0]        pos3;
  } cpte_in_word_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] entry_value;
    logic [STAT_W-1:0]         status;
  } cpte_out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } cpte_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/cpte_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module cpte_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/cp_tensor_entry_eval.sv -----
// CP tensor entry evaluator: factor store and sequenced multiply-accumulate
//
// Input channel (in_valid / in_stall / in_word): a write word stores one Q2.14
// factor value; a query word asks for one tensor entry. Each word gives one
// result word on the output channel (out_valid / out_stall / out_word).
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets dims,
// rank and the four extents; write it only while the block is idle.
// Writes and rejected queries: result registered in the cycle after accept.
// Queries: one factor read and one multiply per cycle through a single
// multiplier fed by the factor RAM; each term's product is added to the sum
// and the saturated sum is registered as the result word.
// in_stall is high while a query is in flight and while a waiting result is
// stalled. A stalled result holds; a finished query waits for the slot.
// Reset (synchronous, rst_n low) sets all config registers to 1 and empties
// the pipeline. The factor RAM is not cleared; entries read before being
// written give undefined values.
`default_nettype none
`include "cp_tensor_entry_eval_defines.svh"

module cp_tensor_entry_eval
  import cpte_pkg::*;
#(
  parameter int unsigned MAX_DIMS   = MAX_DIMS_DEF,
  parameter int unsigned MAX_EXTENT = MAX_EXTENT_DEF,
  parameter int unsigned MAX_RANK   = MAX_RANK_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cpte_in_word_t         in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cpte_out_word_t        out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned RK_W        = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned ND_W        = $clog2(MAX_DIMS + 1);
  localparam int unsigned NR_W        = $clog2(MAX_RANK + 1);
  localparam int unsigned EX_W        = $clog2(MAX_EXTENT + 1);
  localparam int unsigned STORE_DEPTH = MAX_DIMS * MAX_EXTENT * MAX_RANK;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned GROW        = (FRAC_BITS < VAL_W - 1) ? VAL_W - 1 - FRAC_BITS : 0;
  localparam int unsigned ACC_W       = FRAC_BITS + MAX_DIMS * GROW + 2;
  localparam int unsigned PROD_W      = ACC_W + VAL_W;
  localparam int unsigned SUM_W       = ACC_W + NR_W + 1;
  localparam int unsigned EXT_W       = (SUM_W > ENTRY_W) ? SUM_W : ENTRY_W;

  localparam logic signed [ACC_W-1:0] ONE =
    {{(ACC_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(ENTRY_MAX);
  localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(ENTRY_MIN);

  // configuration
  logic [DIMS_REG_W-1:0] dims_r;
  logic [RANK_REG_W-1:0] rank_r;
  logic [EXT_REG_W-1:0]  ext_r [NUM_POS];
  logic [ND_W-1:0]       nd_c;
  logic [NR_W-1:0]       nr_c;
  logic [EX_W-1:0]       ext_c [NUM_POS];

  // sequencer and datapath
  cpte_state_t                state_r, state_nxt;
  logic [DIM_W-1:0]           d_r, d_nxt;
  logic [RK_W-1:0]            r_r, r_nxt;
  logic [POS_W-1:0]           pos_r [MAX_DIMS];
  logic [POS_W-1:0]           in_pos [NUM_POS];
  logic                       rd_vld_r, rd_vld_nxt;
  logic                       rd_first_r, rd_first_nxt;
  logic                       rd_tlast_r, rd_tlast_nxt;
  logic                       add_pend_r, add_pend_nxt;
  logic signed [ACC_W-1:0]    term_r, term_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cpte_out_word_t             out_word_r, out_word_nxt;

  logic                       accept;
  logic                       is_query;
  logic                       wr_err;
  logic                       q_err;
  logic                       last_d;
  logic                       last_r;
  logic                       out_busy;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       ram_we;
  logic [VAL_W-1:0]           ram_rdata;
  logic signed [ACC_W-1:0]    base;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_sh;
  logic signed [EXT_W-1:0]    sum_ext;
  logic signed [ENTRY_W-1:0]  sat_val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_REG_W'(1);
      rank_r <= RANK_REG_W'(1);
      for (int i = 0; i < NUM_POS; i++) begin
        ext_r[i] <= EXT_REG_W'(1);
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIMS: dims_r   <= cfg_data[DIMS_REG_W-1:0];
        CFG_RANK: rank_r   <= cfg_data[RANK_REG_W-1:0];
        CFG_EXT0: ext_r[0] <= cfg_data[EXT_REG_W-1:0];
        CFG_EXT1: ext_r[1] <= cfg_data[EXT_REG_W-1:0];
        CFG_EXT2: ext_r[2] <= cfg_data[EXT_REG_W-1:0];
        CFG_EXT3: ext_r[3] <= cfg_data[EXT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp config into legal ranges
  always_comb begin
    if (dims_r == '0) nd_c = ND_W'(1);
    else if (dims_r > MAX_DIMS) nd_c = ND_W'(MAX_DIMS);
    else nd_c = ND_W'(dims_r);
    if (rank_r == '0) nr_c = NR_W'(1);
    else if (rank_r > MAX_RANK) nr_c = NR_W'(MAX_RANK);
    else nr_c = NR_W'(rank_r);
    for (int i = 0; i < NUM_POS; i++) begin
      if (ext_r[i] == '0) ext_c[i] = EX_W'(1);
      else if (ext_r[i] > MAX_EXTENT) ext_c[i] = EX_W'(MAX_EXTENT);
      else ext_c[i] = EX_W'(ext_r[i]);
    end
  end

  // input checks
  assign in_pos[0] = in_word.pos0;
  assign in_pos[1] = in_word.pos1;
  assign in_pos[2] = in_word.pos2;
  assign in_pos[3] = in_word.pos3;

  assign is_query = (in_word.mode == MODE_QUERY);
  assign wr_err   = (in_word.write_dim >= nd_c) ||
                    (in_word.write_row >= ext_c[in_word.write_dim]) ||
                    (in_word.write_term >= nr_c);

  always_comb begin
    q_err = 1'b0;
    for (int i = 0; i < NUM_POS; i++) begin
      if ((i < nd_c) && (in_pos[i] >= ext_c[i])) begin
        q_err = 1'b1;
      end
    end
  end

  assign out_busy = out_valid_r && out_stall;
  assign in_stall = (state_r != ST_IDLE) || out_busy;
  assign accept   = in_valid && !in_stall;

  // factor store
  assign wr_addr = ADDR_W'((int'(in_word.write_dim) * MAX_EXTENT + int'(in_word.write_row))
                           * MAX_RANK + int'(in_word.write_term));
  assign rd_addr = ADDR_W'((int'(d_r) * MAX_EXTENT + int'(pos_r[d_r])) * MAX_RANK
                           + int'(r_r));
  assign ram_we  = accept && !is_query && !wr_err;

  cpte_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_factor_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (in_word.write_value),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign last_d = (ND_W'(d_r) == nd_c - ND_W'(1));
  assign last_r = (NR_W'(r_r) == nr_c - NR_W'(1));

  // shared multiplier, floor shift into the running term
  assign base    = rd_first_r ? ONE : term_r;
  assign prod    = PROD_W'(base) * PROD_W'($signed(ram_rdata));
  assign prod_sh = prod >>> FRAC_BITS;

  // saturate to the output width
  always_comb begin
    sum_ext = EXT_W'(sum_r);
    if (sum_ext > SAT_HI) sat_val = ENTRY_MAX;
    else if (sum_ext < SAT_LO) sat_val = ENTRY_MIN;
    else sat_val = ENTRY_W'(sum_ext);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_query && !q_err) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (last_d && last_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !add_pend_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output
  always_comb begin
    d_nxt         = d_r;
    r_nxt         = r_r;
    rd_vld_nxt    = (state_r == ST_RUN);
    rd_first_nxt  = (d_r == '0);
    rd_tlast_nxt  = last_d;
    add_pend_nxt  = rd_vld_r && rd_tlast_r;
    term_nxt      = term_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_busy;
    out_word_nxt  = out_word_r;

    if (accept) begin
      d_nxt   = '0;
      r_nxt   = '0;
      sum_nxt = '0;
    end else if (state_r == ST_RUN) begin
      if (last_d) begin
        d_nxt = '0;
        r_nxt = r_r + RK_W'(1);
      end else begin
        d_nxt = d_r + DIM_W'(1);
      end
    end

    if (rd_vld_r) begin
      term_nxt = ACC_W'(prod_sh);
    end
    if (add_pend_r) begin
      sum_nxt = sum_r + SUM_W'(term_r);
    end

    if (accept && (!is_query || q_err)) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.entry_value = '0;
      out_word_nxt.status      = is_query ? STAT_POS_ERR : (wr_err ? STAT_WR_ERR : STAT_OK);
    end else if ((state_r == ST_DONE) && !out_busy) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.entry_value = sat_val;
      out_word_nxt.status      = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      add_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      add_pend_r  <= add_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    r_r        <= r_nxt;
    rd_first_r <= rd_first_nxt;
    rd_tlast_r <= rd_tlast_nxt;
    term_r     <= term_nxt;
    sum_r      <= sum_nxt;
    out_word_r <= out_word_nxt;
    if (accept) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        pos_r[i] <= in_pos[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `CPTE_ASSERT_NEXT(a_accept_progress, accept, (state_r != ST_IDLE) || out_valid_r, "word lost")
  `CPTE_ASSERT_NOW(a_read_in_query, rd_vld_r, (state_r == ST_RUN) || (state_r == ST_DRAIN), "stray read")
  `CPTE_ASSERT_NOW(a_idle_clean, state_r == ST_IDLE, !rd_vld_r && !add_pend_r, "idle with work in flight")

endmodule

`default_nettype wire

// ----- bench/cp_tensor_entry_eval_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cp_tensor_entry_eval: predicts every result word and checks it in order
module cp_tensor_entry_eval_tb;
  import cpte_pkg::*;

  localparam int ITEM_TARGET = 950;
  localparam int CYCLE_LIMIT = 600000;
  localparam int IDLE_MAX    = 18;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 80;
  localparam int STORE_DEPTH = MAX_DIMS_DEF * MAX_EXTENT_DEF * MAX_RANK_DEF;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE0 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE1 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] =
    '{CFG_DIMS, CFG_RANK, CFG_EXT0, CFG_EXT1, CFG_EXT2, CFG_EXT3};

  class entry_tracker;
    logic [DIMS_REG_W-1:0]   dims_reg;
    logic [RANK_REG_W-1:0]   rank_reg;
    logic [EXT_REG_W-1:0]    ext_reg [4];
    logic signed [VAL_W-1:0] factor [STORE_DEPTH];
    bit                      loaded [STORE_DEPTH];
    cpte_out_word_t          pending_entries [$];
    int errors, n_writes, n_wr_rej, n_queries, n_q_rej;

    function new();
      dims_reg = DIMS_REG_W'(1);
      rank_reg = RANK_REG_W'(1);
      foreach (ext_reg[i]) ext_reg[i] = EXT_REG_W'(1);
    endfunction

    function int eff_dims();
      return (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS_DEF) ? MAX_DIMS_DEF : dims_reg;
    endfunction

    function int eff_rank();
      return (rank_reg == 0) ? 1 : (rank_reg > MAX_RANK_DEF) ? MAX_RANK_DEF : rank_reg;
    endfunction

    function int eff_ext(int d);
      return (ext_reg[d] == 0) ? 1 :
             (ext_reg[d] > MAX_EXTENT_DEF) ? MAX_EXTENT_DEF : ext_reg[d];
    endfunction

    function int slot(int d, int row, int term);
      return (d * MAX_EXTENT_DEF + row) * MAX_RANK_DEF + term;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DIMS: dims_reg = data[DIMS_REG_W-1:0];
        CFG_RANK: rank_reg = data[RANK_REG_W-1:0];
        CFG_EXT0: ext_reg[0] = data;
        CFG_EXT1: ext_reg[1] = data;
        CFG_EXT2: ext_reg[2] = data;
        CFG_EXT3: ext_reg[3] = data;
        default: ;
      endcase
    endfunction

    function void note_word(cpte_in_word_t w);
      cpte_out_word_t res;
      longint acc, prod, f;
      int nd, nr, a, d, r;
      int p [4];
      bit bad;
      res.entry_value = '0;
      res.status = STAT_OK;
      nd = eff_dims();
      nr = eff_rank();
      if (w.mode == MODE_WRITE) begin
        n_writes++;
        if (w.write_dim >= nd || w.write_row >= eff_ext(int'(w.write_dim)) ||
            w.write_term >= nr) begin
          res.status = STAT_WR_ERR;
          n_wr_rej++;
        end else begin
          a = slot(int'(w.write_dim), int'(w.write_row), int'(w.write_term));
          factor[a] = w.write_value;
          loaded[a] = 1'b1;
        end
      end else begin
        n_queries++;
        p = '{int'(w.pos0), int'(w.pos1), int'(w.pos2), int'(w.pos3)};
        bad = 1'b0;
        for (d = 0; d < nd; d++) if (p[d] >= eff_ext(d)) bad = 1'b1;
        if (bad) begin
          res.status = STAT_POS_ERR;
          n_q_rej++;
        end else begin
          acc = 0;
          for (r = 0; r < nr; r++) begin
            prod = longint'(1) << FRAC_BITS_DEF;
            for (d = 0; d < nd; d++) begin
              f = longint'(factor[slot(d, p[d], r)]);
              prod = (prod * f) >>> FRAC_BITS_DEF;
            end
            acc += prod;
          end
          if (acc > ENTRY_MAX) acc = longint'(ENTRY_MAX);
          if (acc < ENTRY_MIN) acc = longint'(ENTRY_MIN);
          res.entry_value = acc[ENTRY_W-1:0];
        end
      end
      pending_entries.push_back(res);
    endfunction

    function void check_result(cpte_out_word_t got);
      cpte_out_word_t want;
      if (pending_entries.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: entry_value %0d status %0d",
                 $time, got.entry_value, got.status);
        return;
      end
      want = pending_entries.pop_front();
      if (got.entry_value !== want.entry_value) begin
        errors++;
        $display("%0t: entry_value expected %0d got %0d",
                 $time, want.entry_value, got.entry_value);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  cpte_in_word_t         in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cpte_out_word_t        out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  entry_tracker tracker = new();

  int send_gap_max  = IDLE_MAX;
  int stall_max     = IDLE_MAX;
  int stall_hold    = 0;
  int items_sent    = 0;
  int settings_used = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cp_tensor_entry_eval u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic cpte_in_word_t random_word();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(cpte_in_word_t)-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      4: return 16'hffff;
      default: return raw[VAL_W-1:0];
    endcase
  endfunction

  task automatic send_word(cpte_in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_word(w);
    items_sent++;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_write(int d, int row, int term, logic [VAL_W-1:0] v);
    cpte_in_word_t w;
    w = random_word();
    w.mode        = MODE_WRITE;
    w.write_dim   = d[1:0];
    w.write_row   = row[5:0];
    w.write_term  = term[3:0];
    w.write_value = v;
    send_word(w);
  endtask

  // an in-range query first loads any factor entry it would read that was never written
  task automatic query_entry(int p [4]);
    cpte_in_word_t w;
    int nd, nr, d, r;
    bit hit;
    nd = tracker.eff_dims();
    nr = tracker.eff_rank();
    hit = 1'b1;
    for (d = 0; d < nd; d++) if (p[d] >= tracker.eff_ext(d)) hit = 1'b0;
    if (hit) begin
      for (d = 0; d < nd; d++)
        for (r = 0; r < nr; r++)
          if (!tracker.loaded[tracker.slot(d, p[d], r)])
            send_write(d, p[d], r, pick_value());
    end
    w = random_word();
    w.mode = MODE_QUERY;
    w.pos0 = p[0][POS_W-1:0];
    w.pos1 = p[1][POS_W-1:0];
    w.pos2 = p[2][POS_W-1:0];
    w.pos3 = p[3][POS_W-1:0];
    send_word(w);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
  endtask

  task automatic set_regs(int v [6]);
    int i;
    for (i = 0; i < 6; i++) cfg_write(REG_ORDER[i], v[i][CFG_DATA_W-1:0]);
    cfg_write($urandom_range(0, 1) ? CFG_SPARE0 : CFG_SPARE1, CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : result_sink
    int n;
    forever begin
      if (stall_hold > 0) begin
        n = stall_hold;
        stall_hold = 0;
      end else begin
        n = $urandom_range(0, stall_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      tracker.check_result(out_word);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int regs [6];
    int p [4];
    int phase, units, unit_max, sel, k, d, e, nd, nr;
    bit full;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: one dimension, one term, extent one
    send_write(0, 0, 0, 16'h7fff);
    send_write(1, 0, 0, 16'h1234);
    send_write(0, 1, 0, 16'h1234);
    send_write(0, 0, 1, 16'h1234);
    query_entry('{0, 63, 63, 63});
    query_entry('{1, 0, 0, 0});
    drain();

    set_regs('{4, 1, 64, 64, 64, 64});
    for (d = 0; d < 4; d++) send_write(d, 63, 0, 16'h8000);
    query_entry('{63, 63, 63, 63});
    // -1 times 1.0 floors towards minus infinity
    send_write(0, 5, 0, 16'hffff);
    for (d = 1; d < 4; d++) send_write(d, 5, 0, 16'h4000);
    query_entry('{5, 5, 5, 5});
    drain();

    // raw values outside the legal ranges are clamped
    set_regs('{7, 0, 127, 0, 2, 64});
    query_entry('{63, 0, 1, 63});
    query_entry('{63, 1, 0, 0});
    send_write(1, 1, 0, 16'h0001);
    send_write(3, 63, 15, 16'h0001);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      full = (phase % 8 == 3);
      if (full) begin
        regs = '{4, 16, 64, 64, 64, 64};
      end else begin
        sel = $urandom_range(0, 9);
        regs[0] = (sel == 0) ? $urandom_range(5, 7) : (sel == 1) ? 0 : $urandom_range(1, 4);
        regs[1] = (sel == 2) ? $urandom_range(17, 31) : (sel == 3) ? 0 :
                  $urandom_range(1, (sel < 6) ? 16 : 4);
        for (e = 0; e < 4; e++) begin
          k = $urandom_range(0, 19);
          regs[2 + e] = (k == 0) ? 0 : (k == 1) ? $urandom_range(65, 127) :
                        (k == 2) ? 64 : $urandom_range(1, 6);
        end
      end
      set_regs(regs);
      nd = tracker.eff_dims();
      nr = tracker.eff_rank();

      send_gap_max = (phase % 4 == 1) ? 0 : IDLE_MAX;
      stall_max    = send_gap_max;
      if (phase == 2) begin
        stall_hold   = HOLD_OFF;
        send_gap_max = 0;
      end
      unit_max = full ? 12 : 40;

      for (units = 0; units < unit_max && items_sent < ITEM_TARGET; units++) begin
        if (phase == 4 && units == unit_max / 2) drain();
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          for (d = 0; d < 4; d++) begin
            if (d >= nd) p[d] = $urandom_range(0, 63);
            else case ($urandom_range(0, 3))
              0: p[d] = 0;
              1: p[d] = tracker.eff_ext(d) - 1;
              default: p[d] = $urandom_range(0, tracker.eff_ext(d) - 1);
            endcase
          end
          query_entry(p);
        end else if (sel < 80) begin
          d = $urandom_range(0, nd - 1);
          send_write(d, $urandom_range(0, tracker.eff_ext(d) - 1),
                     $urandom_range(0, nr - 1), pick_value());
        end else if (sel < 90) begin
          send_write($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 15),
                     pick_value());
        end else begin
          for (d = 0; d < 4; d++) p[d] = $urandom_range(0, 63);
          query_entry(p);
        end
      end
      phase++;
    end

    drain();
    repeat (TAIL) @(posedge clk);
    $display("covered %0d factor writes (%0d rejected) and %0d entry queries (%0d rejected)",
             tracker.n_writes, tracker.n_wr_rej, tracker.n_queries, tracker.n_q_rej);
    $display("across %0d register settings, with a long output hold-off and a mid-phase drain",
             settings_used);
    if (tracker.errors == 0 && tracker.pending_entries.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- cp_tensor_entry_eval.f -----
+incdir+rtl/core
rtl/core/cpte_pkg.sv
rtl/core/cpte_ram.sv
rtl/core/cp_tensor_entry_eval.sv
bench/cp_tensor_entry_eval_tb.sv
